/* src/cqe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqe_pkg
// Shared sizes, operation and status codes, state type and word helpers for
// the circular queue engine.
// ----------------------------------------------------------------------------
package cqe_pkg;

   localparam int DEPTH       = 64;
   localparam int WORD_BITS   = 32;
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int DATA_BITS   = 32;
   localparam int OCC_BITS    = 7;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_PEEK    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_DISPLAY = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } cqe_state_type;

   function automatic logic [IDX_BITS-1:0] next_index(input logic [IDX_BITS-1:0] i);
      return (i == IDX_BITS'(DEPTH - 1)) ? '0 : IDX_BITS'(i + 1'b1);
   endfunction

   // keep the low word bits of the sign-extended request value
   function automatic logic [WORD_BITS-1:0] word_in(input logic [DATA_BITS-1:0] v);
      return WORD_BITS'($signed(v));
   endfunction

   // sign-extend a stored word and cut it to the data field
   function automatic logic [DATA_BITS-1:0] word_out(input logic [WORD_BITS-1:0] w);
      return DATA_BITS'($signed(w));
   endfunction

endpackage
`default_nettype wire

/* src/cqe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cqe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cqe_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* src/circular_queue_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_engine
// Ring-buffer queue of signed words held in a synchronous RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every result shows
// on the rsp_ ports for one cycle with rsp_strobe high, and the receiver
// cannot stall. An enqueue, or any request on an empty queue, answers on the
// next cycle and leaves busy low, so such requests run one per cycle. A
// dequeue or peek of a stored word raises busy while ST_READ takes the word
// from the registered read data of the slot RAM. A display of N words sends
// one word per cycle through the RAM read port, with rsp_last_of_run on the
// final word. Reset needs no clearing pass.
module circular_queue_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cqe_pkg::OP_BITS-1:0]         req_type,
   input  wire logic signed [cqe_pkg::DATA_BITS-1:0] req_push_value,
   output logic                                     rsp_strobe,
   output logic signed [cqe_pkg::DATA_BITS-1:0]     rsp_data_word,
   output logic [cqe_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [cqe_pkg::OCC_BITS-1:0]             rsp_occupancy,
   output logic                                     rsp_empty_flag,
   output logic                                     rsp_full_flag,
   output logic                                     rsp_last_of_run
);

   cqe_pkg::cqe_state_type state_ff, state_in;

   logic [cqe_pkg::IDX_BITS-1:0]    head_ff, head_in;
   logic [cqe_pkg::IDX_BITS-1:0]    tail_ff, tail_in;
   logic [cqe_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic [cqe_pkg::IDX_BITS-1:0]    show_ptr_ff, show_ptr_in;
   logic [cqe_pkg::CNT_BITS-1:0]    left_ff, left_in;

   logic                            strobe_ff, strobe_in;
   logic [cqe_pkg::DATA_BITS-1:0]   data_ff, data_in;
   logic [cqe_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                            last_ff, last_in;
   logic [cqe_pkg::OCC_BITS-1:0]    occ_ff;
   logic                            empty_ff, full_ff;

   logic                            accept;
   logic                            is_empty, is_full;

   logic                            ram_wr_en;
   logic [cqe_pkg::IDX_BITS-1:0]    ram_wr_addr;
   logic [cqe_pkg::WORD_BITS-1:0]   ram_wr_data;
   logic                            ram_rd_en;
   logic [cqe_pkg::IDX_BITS-1:0]    ram_rd_addr;
   logic [cqe_pkg::WORD_BITS-1:0]   ram_rd_data;

   assign busy     = (state_ff != cqe_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == cqe_pkg::CNT_BITS'(cqe_pkg::DEPTH));

   cqe_ram #(
      .WIDTH (cqe_pkg::WORD_BITS),
      .DEPTH (cqe_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cqe_pkg::ST_IDLE: begin
            if (accept && !is_empty) begin
               if (req_type == cqe_pkg::OP_DEQUEUE || req_type == cqe_pkg::OP_PEEK) begin
                  state_in = cqe_pkg::ST_READ;
               end else if (req_type == cqe_pkg::OP_DISPLAY) begin
                  state_in = cqe_pkg::ST_SHOW;
               end
            end
         end
         cqe_pkg::ST_READ: begin
            state_in = cqe_pkg::ST_IDLE;
         end
         cqe_pkg::ST_SHOW: begin
            if (left_ff == cqe_pkg::CNT_BITS'(1)) begin
               state_in = cqe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cqe_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      show_ptr_in = show_ptr_ff;
      left_in     = left_ff;
      strobe_in   = 1'b0;
      data_in     = '0;
      status_in   = cqe_pkg::STATUS_OK;
      last_in     = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = cqe_pkg::word_in(req_push_value);
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      unique case (state_ff)
         cqe_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  cqe_pkg::OP_ENQUEUE: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        status_in = cqe_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        tail_in   = cqe_pkg::next_index(tail_ff);
                        count_in  = cqe_pkg::CNT_BITS'(count_ff + 1'b1);
                     end
                  end
                  cqe_pkg::OP_DEQUEUE: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = cqe_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en = 1'b1;
                        head_in   = cqe_pkg::next_index(head_ff);
                        count_in  = cqe_pkg::CNT_BITS'(count_ff - 1'b1);
                     end
                  end
                  cqe_pkg::OP_PEEK: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = cqe_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en = 1'b1;
                     end
                  end
                  cqe_pkg::OP_DISPLAY: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = cqe_pkg::STATUS_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        show_ptr_in = cqe_pkg::next_index(head_ff);
                        left_in     = count_ff;
                     end
                  end
               endcase
            end
         end
         cqe_pkg::ST_READ: begin
            strobe_in = 1'b1;
            data_in   = cqe_pkg::word_out(ram_rd_data);
         end
         cqe_pkg::ST_SHOW: begin
            strobe_in = 1'b1;
            data_in   = cqe_pkg::word_out(ram_rd_data);
            last_in   = (left_ff == cqe_pkg::CNT_BITS'(1));
            // fetch the next word while this one goes out
            if (!last_in) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = show_ptr_ff;
               show_ptr_in = cqe_pkg::next_index(show_ptr_ff);
               left_in     = cqe_pkg::CNT_BITS'(left_ff - 1'b1);
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cqe_pkg::ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         show_ptr_ff <= '0;
         left_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         show_ptr_ff <= show_ptr_in;
         left_ff     <= left_in;
         strobe_ff   <= strobe_in;
      end
   end

   // result payload, flags taken from the count after the request
   always_ff @(posedge clock) begin
      if (strobe_in) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         last_ff   <= last_in;
         occ_ff    <= cqe_pkg::OCC_BITS'(count_in);
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in == cqe_pkg::CNT_BITS'(cqe_pkg::DEPTH));
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_data_word   = data_ff;
   assign rsp_status      = status_ff;
   assign rsp_occupancy   = occ_ff;
   assign rsp_empty_flag  = empty_ff;
   assign rsp_full_flag   = full_ff;
   assign rsp_last_of_run = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept && req_type == cqe_pkg::OP_ENQUEUE |=> rsp_strobe && rsp_last_of_run)
      else $error("enqueue request gave no single result");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cqe_pkg::CNT_BITS'(cqe_pkg::DEPTH))
      else $error("occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == cqe_pkg::STATUS_FULL |-> rsp_full_flag)
      else $error("full status without full flag");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && rsp_last_of_run)
      else $error("busy dropped without final result");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == cqe_pkg::ST_READ |=> state_ff == cqe_pkg::ST_IDLE)
      else $error("read state held more than one cycle");

endmodule
`default_nettype wire
